[hdl/rcl_pkg.sv]
package rcl_pkg;

	localparam int unsigned LETTERS = 26;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

	typedef logic [4:0] letter_t;

	localparam letter_t LAST_POS = letter_t'(LETTERS - 1);

	typedef struct packed {
		letter_t letter;
		letter_t fast;
		letter_t mid;
		letter_t slow;
	} rcl_req_t;

	localparam letter_t FAST_FWD [LETTERS] = '{
		5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd2, 5'd15, 5'd17, 5'd19, 5'd23, 5'd21, 5'd25,
		5'd13, 5'd24, 5'd4, 5'd8, 5'd22, 5'd6, 5'd0, 5'd10, 5'd12, 5'd20, 5'd18, 5'd16, 5'd14
	};
	localparam letter_t FAST_INV [LETTERS] = '{
		5'd19, 5'd0, 5'd6, 5'd1, 5'd15, 5'd2, 5'd18, 5'd3, 5'd16, 5'd4, 5'd20, 5'd5, 5'd21,
		5'd13, 5'd25, 5'd7, 5'd24, 5'd8, 5'd23, 5'd9, 5'd22, 5'd11, 5'd17, 5'd10, 5'd14, 5'd12
	};
	localparam letter_t MEDIUM_FWD [LETTERS] = '{
		5'd0, 5'd9, 5'd3, 5'd10, 5'd18, 5'd8, 5'd17, 5'd20, 5'd23, 5'd1, 5'd11, 5'd7, 5'd22,
		5'd19, 5'd12, 5'd2, 5'd16, 5'd6, 5'd25, 5'd13, 5'd15, 5'd24, 5'd5, 5'd21, 5'd14, 5'd4
	};
	localparam letter_t MEDIUM_INV [LETTERS] = '{
		5'd0, 5'd9, 5'd15, 5'd2, 5'd25, 5'd22, 5'd17, 5'd11, 5'd5, 5'd1, 5'd3, 5'd10, 5'd14,
		5'd19, 5'd24, 5'd20, 5'd16, 5'd6, 5'd4, 5'd13, 5'd7, 5'd23, 5'd12, 5'd8, 5'd21, 5'd18
	};
	localparam letter_t SLOW_FWD [LETTERS] = '{
		5'd4, 5'd10, 5'd12, 5'd5, 5'd11, 5'd6, 5'd3, 5'd16, 5'd21, 5'd25, 5'd13, 5'd19, 5'd14,
		5'd22, 5'd24, 5'd7, 5'd23, 5'd20, 5'd18, 5'd15, 5'd0, 5'd8, 5'd1, 5'd17, 5'd2, 5'd9
	};
	localparam letter_t SLOW_INV [LETTERS] = '{
		5'd20, 5'd22, 5'd24, 5'd6, 5'd0, 5'd3, 5'd5, 5'd15, 5'd21, 5'd25, 5'd1, 5'd4, 5'd2,
		5'd10, 5'd12, 5'd19, 5'd7, 5'd23, 5'd18, 5'd11, 5'd17, 5'd8, 5'd13, 5'd16, 5'd14, 5'd9
	};
	localparam letter_t REFLECT [LETTERS] = '{
		5'd8, 5'd23, 5'd20, 5'd7, 5'd5, 5'd4, 5'd25, 5'd3, 5'd0, 5'd14, 5'd12, 5'd19, 5'd10,
		5'd16, 5'd9, 5'd22, 5'd13, 5'd18, 5'd17, 5'd11, 5'd2, 5'd24, 5'd15, 5'd1, 5'd21, 5'd6
	};

	function automatic letter_t add26(letter_t a, letter_t b);
		logic [5:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= 6'(LETTERS)) begin
			s = s - 6'(LETTERS);
		end
		return s[4:0];
	endfunction

	function automatic letter_t sub26(letter_t a, letter_t b);
		logic [5:0] d;
		if (a >= b) begin
			d = {1'b0, a} - {1'b0, b};
		end else begin
			d = {1'b0, a} + 6'(LETTERS) - {1'b0, b};
		end
		return d[4:0];
	endfunction

endpackage

[hdl/rcl_front.sv]
module rcl_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rcl_pkg::letter_t plain_letter,
	input  logic             restart,
	input  logic             q_full,
	output logic             q_push,
	output rcl_pkg::rcl_req_t q_data
);
	import rcl_pkg::*;

	letter_t fast_q, medium_q, slow_q;
	letter_t fast_eff, medium_eff, slow_eff;
	letter_t fast_nxt, medium_nxt, slow_nxt;
	letter_t letter_red;

	assign q_push = push && !q_full;

	always_comb begin
		if (restart) begin
			fast_eff = letter_t'(1);
			medium_eff = '0;
			slow_eff = '0;
		end else begin
			fast_eff = fast_q;
			medium_eff = medium_q;
			slow_eff = slow_q;
		end
		fast_nxt = fast_eff;
		medium_nxt = medium_eff;
		slow_nxt = slow_eff;
		if (fast_eff == LAST_POS) begin
			fast_nxt = '0;
			if (medium_eff == LAST_POS) begin
				medium_nxt = '0;
				slow_nxt = (slow_eff == LAST_POS) ? '0 : slow_eff + letter_t'(1);
			end else begin
				medium_nxt = medium_eff + letter_t'(1);
			end
		end else begin
			fast_nxt = fast_eff + letter_t'(1);
		end
	end

	// Letter codes above Z wrap around onto A through F.
	assign letter_red = (plain_letter >= letter_t'(LETTERS)) ?
		plain_letter - letter_t'(LETTERS) : plain_letter;

	assign q_data = '{letter: letter_red, fast: fast_eff, mid: medium_eff, slow: slow_eff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_q <= letter_t'(1);
			medium_q <= '0;
			slow_q <= '0;
		end else if (q_push) begin
			fast_q <= fast_nxt;
			medium_q <= medium_nxt;
			slow_q <= slow_nxt;
		end
	end

endmodule

[hdl/rcl_queue.sv]
module rcl_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  rcl_pkg::rcl_req_t wr_data,
	input  logic              rd_en,
	output rcl_pkg::rcl_req_t rd_data,
	output logic              full,
	output logic              empty
);
	import rcl_pkg::*;

	rcl_req_t entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0] count_q;

	assign full = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/rcl_back.sv]
module rcl_back (
	input  logic              clk,
	input  logic              arst_n,
	input  rcl_pkg::rcl_req_t q_data,
	input  logic              q_empty,
	output logic              q_pop,
	input  logic              pop,
	output logic              empty,
	output rcl_pkg::letter_t  cipher_letter
);
	import rcl_pkg::*;

	logic advance;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	letter_t x_s1, x_s2, x_s3, x_s4, x_s5, x_s6;
	letter_t f_s1, m_s1, s_s1;
	letter_t f_s2, m_s2, s_s2;
	letter_t f_s3, m_s3, s_s3;
	letter_t f_s4, m_s4;
	letter_t f_s5;
	letter_t refl;

	// The whole pipeline moves together unless the finished letter is held.
	assign advance = !v_s6 || pop;
	assign q_pop = advance && !q_empty;
	assign empty = !v_s6;
	assign cipher_letter = x_s6;
	assign refl = REFLECT[x_s3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (advance) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			x_s1 <= sub26(FAST_FWD[add26(q_data.letter, q_data.fast)], q_data.fast);
			f_s1 <= q_data.fast;
			m_s1 <= q_data.mid;
			s_s1 <= q_data.slow;

			x_s2 <= sub26(MEDIUM_FWD[add26(x_s1, m_s1)], m_s1);
			f_s2 <= f_s1;
			m_s2 <= m_s1;
			s_s2 <= s_s1;

			x_s3 <= sub26(SLOW_FWD[add26(x_s2, s_s2)], s_s2);
			f_s3 <= f_s2;
			m_s3 <= m_s2;
			s_s3 <= s_s2;

			x_s4 <= sub26(SLOW_INV[add26(refl, s_s3)], s_s3);
			f_s4 <= f_s3;
			m_s4 <= m_s3;

			x_s5 <= sub26(MEDIUM_INV[add26(x_s4, m_s4)], m_s4);
			f_s5 <= f_s4;

			x_s6 <= sub26(FAST_INV[add26(x_s5, f_s5)], f_s5);
		end
	end

endmodule

[hdl/rotor_cipher_letter_stream.sv]
// Three-rotor letter cipher with a queue-style interface on both sides.
// Input channel: drive plain_letter and restart, raise push; the request is
// taken at a rising edge where push is high and full is low. Setting restart
// puts the rotors back to the message start position before that letter.
// Result channel: while empty is low, cipher_letter holds the oldest result;
// it is taken at a rising edge where pop is high and empty is low.
// After the accepting edge, a letter passes through the request queue and the
// six table stages of the cipher pipeline before empty goes low.
// Throughput is one letter per cycle in steady state with pop held high.
// If the receiver stops popping, the pipeline freezes in place and the
// four-entry request queue keeps taking letters until it fills; full then
// rises until pop resumes. Rotor stepping happens at acceptance, so stalls
// never change the cipher output.
// Reset clears the queue and pipeline (empty high, full low) and sets the
// rotors to the message start position.
module rotor_cipher_letter_stream (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  rcl_pkg::letter_t plain_letter,
	input  logic             restart,
	output logic             empty,
	input  logic             pop,
	output rcl_pkg::letter_t cipher_letter
);
	import rcl_pkg::*;

	logic q_push, q_pop, q_empty;
	rcl_req_t q_wr_data, q_rd_data;

	rcl_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.plain_letter (plain_letter),
		.restart      (restart),
		.q_full       (full),
		.q_push       (q_push),
		.q_data       (q_wr_data)
	);

	rcl_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr_data),
		.rd_en   (q_pop),
		.rd_data (q_rd_data),
		.full    (full),
		.empty   (q_empty)
	);

	rcl_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_data        (q_rd_data),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.pop           (pop),
		.empty         (empty),
		.cipher_letter (cipher_letter)
	);

endmodule

[hdl/rcl_checker.sv]
module rcl_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             push,
	input logic             full,
	input rcl_pkg::letter_t plain_letter,
	input logic             restart,
	input logic             empty,
	input logic             pop,
	input rcl_pkg::letter_t cipher_letter
);
	import rcl_pkg::*;

	a_letter_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (cipher_letter <= LAST_POS))
		else $error("cipher letter outside A to Z");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(cipher_letter)))
		else $error("waiting result changed before it was popped");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> empty)
		else $error("result shown during reset");

	a_reset_not_full: assert property (@(posedge clk)
		!arst_n |-> !full)
		else $error("full raised during reset");

endmodule

bind rotor_cipher_letter_stream rcl_checker u_rcl_checker (.*);

[verif/rotor_cipher_letter_stream_tb.sv]
`timescale 1ns / 1ps

module rotor_cipher_letter_stream_tb;
	import rcl_pkg::*;

	localparam string FAST_WIRING = "BDFHJLCPRTXVZNYEIWGAKMUSQO";
	localparam string MID_WIRING = "AJDKSIRUXBLHWTMCQGZNPYFVOE";
	localparam string SLOW_WIRING = "EKMFLGDQVZNTOWYHXUSPAIBRCJ";
	localparam string REFLECTOR_WIRING = "IXUHFEZDAOMTKQJWNSRLCYPBVG";
	localparam byte CHAR_A = "A";
	localparam int ALPHABET = 26;
	localparam int NOT_TYPED = -1;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		letter_t letter;
		logic    rst;
		int      want;
	} letter_row_t;

	logic    clk;
	logic    arst_n;
	logic    push = 1'b0;
	logic    full;
	letter_t plain_letter = '0;
	logic    restart = 1'b0;
	logic    empty;
	logic    pop = 1'b0;
	letter_t cipher_letter;

	int      typed_want = NOT_TYPED;
	int      send_idle = 35;
	int      recv_idle = 48;
	int      mismatches = 0;
	int      stall_cycles = 0;
	int      fast_pos = 1;
	int      mid_pos = 0;
	int      slow_pos = 0;
	letter_t cipher_q[$];
	letter_t predicted;
	letter_t oldest;

	// Rows with a typed result sit at the start position, where A enciphers to Z.
	letter_row_t dir_rows [0:15] = '{
		'{5'd0, 1'b0, 25},
		'{5'd25, 1'b0, NOT_TYPED},
		'{5'd31, 1'b0, NOT_TYPED},
		'{5'd26, 1'b1, 25},
		'{5'd0, 1'b1, 25},
		'{5'd27, 1'b0, NOT_TYPED},
		'{5'd1, 1'b0, NOT_TYPED},
		'{5'd28, 1'b0, NOT_TYPED},
		'{5'd2, 1'b0, NOT_TYPED},
		'{5'd29, 1'b0, NOT_TYPED},
		'{5'd30, 1'b0, NOT_TYPED},
		'{5'd31, 1'b1, NOT_TYPED},
		'{5'd25, 1'b1, NOT_TYPED},
		'{5'd12, 1'b0, NOT_TYPED},
		'{5'd13, 1'b0, NOT_TYPED},
		'{5'd25, 1'b0, NOT_TYPED}
	};

	rotor_cipher_letter_stream uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.plain_letter(plain_letter),
		.restart(restart),
		.empty(empty),
		.pop(pop),
		.cipher_letter(cipher_letter)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int wire_fwd(string w, int x);
		return int'(w[x]) - int'(CHAR_A);
	endfunction

	function automatic int wire_back(string w, int x);
		int j;
		for (j = 0; j < ALPHABET; j++) begin
			if (wire_fwd(w, j) == x) begin
				return j;
			end
		end
		return 0;
	endfunction

	function automatic int rotor_pass(int x, int pos, string w, bit back);
		int s;
		int t;
		s = (x + pos) % ALPHABET;
		t = back ? wire_back(w, s) : wire_fwd(w, s);
		return (t + ALPHABET - pos) % ALPHABET;
	endfunction

	function automatic letter_t encipher_letter(letter_t plain, logic rst);
		int x;
		if (rst) begin
			fast_pos = 1;
			mid_pos = 0;
			slow_pos = 0;
		end
		x = int'(plain);
		x = rotor_pass(x, fast_pos, FAST_WIRING, 1'b0);
		x = rotor_pass(x, mid_pos, MID_WIRING, 1'b0);
		x = rotor_pass(x, slow_pos, SLOW_WIRING, 1'b0);
		x = wire_fwd(REFLECTOR_WIRING, x);
		x = rotor_pass(x, slow_pos, SLOW_WIRING, 1'b1);
		x = rotor_pass(x, mid_pos, MID_WIRING, 1'b1);
		x = rotor_pass(x, fast_pos, FAST_WIRING, 1'b1);
		fast_pos++;
		if (fast_pos == ALPHABET) begin
			fast_pos = 0;
			mid_pos++;
			if (mid_pos == ALPHABET) begin
				mid_pos = 0;
				slow_pos = (slow_pos + 1) % ALPHABET;
			end
		end
		return letter_t'(x);
	endfunction

	function automatic letter_t random_letter();
		if ($urandom_range(7) == 0) begin
			return letter_t'($urandom_range(31, 26));
		end
		return letter_t'($urandom_range(25));
	endfunction

	task automatic send_letter(letter_t l, logic r, int want);
		bit done;
		done = 1'b0;
		while (!done) begin
			@(negedge clk);
			if ($urandom_range(99) < send_idle) begin
				push <= 1'b0;
			end else begin
				push <= 1'b1;
				plain_letter <= l;
				restart <= r;
				typed_want <= want;
				@(posedge clk);
				done = !full;
			end
		end
	endtask

	task automatic send_random(int count);
		int i;
		for (i = 0; i < count; i++) begin
			send_letter(random_letter(), $urandom_range(63) == 0, NOT_TYPED);
		end
	endtask

	initial begin
		forever begin
			@(negedge clk);
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
			if (push && !full) begin
				predicted = encipher_letter(plain_letter, restart);
				if (typed_want != NOT_TYPED) begin
					cipher_q.push_back(letter_t'(typed_want));
				end else begin
					cipher_q.push_back(predicted);
				end
			end
			if (pop && !empty) begin
				if (cipher_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected result: cipher_letter %0d", cipher_letter);
					end
				end else begin
					oldest = cipher_q.pop_front();
					if (cipher_letter !== oldest) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: cipher_letter expected %0d actual %0d",
								oldest, cipher_letter);
						end
					end
				end
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		int i;
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < 16; i++) begin
			send_letter(dir_rows[i].letter, dir_rows[i].rst, dir_rows[i].want);
		end
		send_random(630);

		// Let the pipeline drain completely before the idling changes sides.
		@(negedge clk);
		push <= 1'b0;
		wait (cipher_q.size() == 0);

		send_idle = 48;
		recv_idle = 35;
		send_random(630);

		send_idle = 0;
		recv_idle = 0;
		send_random(640);

		@(negedge clk);
		push <= 1'b0;
		wait (cipher_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && cipher_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/rcl_pkg.sv
hdl/rcl_front.sv
hdl/rcl_queue.sv
hdl/rcl_back.sv
hdl/rotor_cipher_letter_stream.sv
hdl/rcl_checker.sv
verif/rotor_cipher_letter_stream_tb.sv
